>>> hdl/pext_pkg.sv
// shared types, constants and widths for the pose extrapolator
package pext_pkg;

   localparam int Axes  = 6;
   localparam int PoseW = 32;
   localparam int TimeW = 32;
   localparam int RegW  = 20;
   localparam int FracW = 16;
   localparam int DivW  = TimeW + FracW;
   localparam int CsrIdxW = 2;

   localparam logic [RegW-1:0] KneeReset = 20'd196608;
   localparam logic [RegW-1:0] AsymReset = 20'd327680;

   localparam logic [CsrIdxW-1:0] CsrKnee = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrAsym = 2'd1;

   localparam logic FuncStore = 1'b0;
   localparam logic FuncQuery = 1'b1;

   typedef logic signed [PoseW-1:0] pose_type;

   typedef struct packed {
      logic             func;
      logic [TimeW-1:0] time_stamp;
      pose_type         in_yaw;
      pose_type         in_pitch;
      pose_type         in_roll;
      pose_type         in_x;
      pose_type         in_y;
      pose_type         in_z;
      logic [31:0]      in_count;
      logic [31:0]      known_count;
      logic             tracker_ok;
   } req_word_type;

   typedef struct packed {
      pose_type    out_yaw;
      pose_type    out_pitch;
      pose_type    out_roll;
      pose_type    out_x;
      pose_type    out_y;
      pose_type    out_z;
      logic [31:0] out_count;
      logic        new_data;
   } rsp_word_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [5:0] {
      StIdle = 6'b000001,
      StDiv1 = 6'b000010,
      StMul  = 6'b000100,
      StDiv2 = 6'b001000,
      StLane = 6'b010000,
      StFin  = 6'b100000
   } state_type;

endpackage

>>> hdl/pose_extrapolator_core.sv
// pose extrapolator top level: frame store, ratio sequencer, six lanes, result merge
// store word: taken while the sequencer is idle, no response
// query word: one 48-step divider pass if the ratio is not over the knee, two on the curve,
//    none on a zero frame interval or with the tracker down
// one query in flight at a time; the next word is taken while a response waits on rsp_stall
// synchronous reset clears the stored poses, times, count and restores the knee and asymptote
module pose_extrapolator_core import pext_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_word_type       req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_word_type       rsp_word,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [RegW-1:0]    csr_data
);

   state_type state_ff, state_in;

   logic [RegW-1:0]  knee_ff, asym_ff;
   pose_type         last_pose_ff [Axes];
   pose_type         old_pose_ff  [Axes];
   pose_type         in_pose      [Axes];
   pose_type         lane_res     [Axes];
   logic [TimeW-1:0] last_time_ff, prev_time_ff;
   logic [31:0]      count_ff;
   logic [31:0]      known_ff;
   logic             ok_ff;
   logic [DivW-1:0]  r_ff;
   logic [2*RegW-1:0] prod_ff;
   logic [RegW-1:0]  ext_ff;
   logic             rsp_valid_ff;
   rsp_word_type     rsp_word_ff, merged;

   logic             req_take;
   logic             slot_free;
   logic [TimeW-1:0] num, den;
   logic             gap_neg;
   logic [RegW-1:0]  abs_gap;
   logic             div_start;
   logic [DivW-1:0]  div_dividend, div_divisor, div_quotient;
   div_stat_type     div_stat;

   assign req_stall = (state_ff != StIdle);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign num     = req_word.time_stamp - last_time_ff;
   assign den     = last_time_ff - prev_time_ff;
   assign gap_neg = asym_ff < knee_ff;
   assign abs_gap = gap_neg ? (knee_ff - asym_ff) : (asym_ff - knee_ff);

   assign in_pose[0] = req_word.in_yaw;
   assign in_pose[1] = req_word.in_pitch;
   assign in_pose[2] = req_word.in_roll;
   assign in_pose[3] = req_word.in_x;
   assign in_pose[4] = req_word.in_y;
   assign in_pose[5] = req_word.in_z;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      unique case (state_ff)
         StIdle: begin
            if (req_take && req_word.func == FuncQuery) begin
               if (!req_word.tracker_ok) begin
                  state_in = StFin;
               end else if (den == '0) begin
                  state_in = StLane;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = {num, {FracW{1'b0}}};
                  div_divisor  = DivW'(den);
                  state_in     = StDiv1;
               end
            end
         end
         StDiv1: begin
            if (div_stat.done) begin
               if (div_quotient <= DivW'(knee_ff)) begin
                  state_in = StLane;
               end else begin
                  state_in = StMul;
               end
            end
         end
         StMul: begin
            div_start    = 1'b1;
            div_dividend = DivW'(prod_ff);
            div_divisor  = r_ff;
            state_in     = StDiv2;
         end
         StDiv2: begin
            if (div_stat.done) begin
               state_in = StLane;
            end
         end
         StLane: begin
            state_in = StFin;
         end
         StFin: begin
            if (slot_free) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   // config registers and stored frame
   always_ff @(posedge clock) begin
      if (reset) begin
         knee_ff      <= KneeReset;
         asym_ff      <= AsymReset;
         last_time_ff <= '0;
         prev_time_ff <= '0;
         count_ff     <= '0;
         for (int a = 0; a < Axes; a++) begin
            last_pose_ff[a] <= '0;
            old_pose_ff[a]  <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CsrKnee: knee_ff <= csr_data;
               CsrAsym: asym_ff <= csr_data;
               default: ;
            endcase
         end
         if (req_take && req_word.func == FuncStore) begin
            prev_time_ff <= last_time_ff;
            last_time_ff <= req_word.time_stamp;
            count_ff     <= req_word.in_count;
            for (int a = 0; a < Axes; a++) begin
               old_pose_ff[a]  <= last_pose_ff[a];
               last_pose_ff[a] <= in_pose[a];
            end
         end
      end
   end

   // ratio datapath
   always_ff @(posedge clock) begin
      if (req_take && req_word.func == FuncQuery) begin
         known_ff <= req_word.known_count;
         ok_ff    <= req_word.tracker_ok;
         ext_ff   <= '0;
      end
      if (state_ff == StDiv1 && div_stat.done) begin
         r_ff    <= div_quotient;
         ext_ff  <= div_quotient[RegW-1:0];
         prod_ff <= (2*RegW)'(knee_ff) * (2*RegW)'(abs_gap);
      end
      if (state_ff == StDiv2 && div_stat.done) begin
         ext_ff <= gap_neg ? (asym_ff + div_quotient[RegW-1:0])
                           : (asym_ff - div_quotient[RegW-1:0]);
      end
   end

   pext_div #(
      .Width (DivW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   for (genvar a = 0; a < Axes; a++) begin : g_lane
      pext_lane u_lane (
         .clock  (clock),
         .prev   (old_pose_ff[a]),
         .last   (last_pose_ff[a]),
         .ext    (ext_ff),
         .result (lane_res[a])
      );
   end

   // merge lanes into the response word
   always_comb begin
      merged.out_yaw   = lane_res[0];
      merged.out_pitch = lane_res[1];
      merged.out_roll  = lane_res[2];
      merged.out_x     = lane_res[3];
      merged.out_y     = lane_res[4];
      merged.out_z     = lane_res[5];
      merged.out_count = count_ff;
      merged.new_data  = (count_ff != known_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == StFin && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == StFin && slot_free) begin
         rsp_word_ff <= ok_ff ? merged : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == StFin))
      else $error("response raised outside the finish state");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   a_curve_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StDiv2) |-> (r_ff > DivW'(knee_ff)))
      else $error("curve division with ratio under the knee");

endmodule

>>> hdl/pext_div.sv
// shared restoring divider, one quotient bit per cycle
module pext_div import pext_pkg::*; #(
   parameter int Width = DivW
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [Width-1:0] dividend,
   input  logic [Width-1:0] divisor,
   output logic [Width-1:0] quotient,
   output div_stat_type     stat
);

   localparam int CntW = $clog2(Width);

   logic [Width-1:0] rem_ff, rem_in;
   logic [Width-1:0] quo_ff, quo_in;
   logic [Width-1:0] dsr_ff;
   logic [CntW-1:0]  cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [Width:0]   trial;
   logic [Width:0]   diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[Width-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};
   assign rem_in = fits ? diff[Width-1:0] : trial[Width-1:0];
   assign quo_in = {quo_ff[Width-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CntW'(Width - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

>>> hdl/pext_lane.sv
// one axis lane: difference times ratio, floor shift, add and saturate
module pext_lane import pext_pkg::*; (
   input  logic            clock,
   input  pose_type        prev,
   input  pose_type        last,
   input  logic [RegW-1:0] ext,
   output pose_type        result
);

   localparam int ProdW = PoseW + RegW + 2;
   localparam int SumW  = PoseW + RegW - FracW + 3;

   logic signed [PoseW:0]   diff;
   logic signed [ProdW-1:0] prod_in, prod_ff;
   logic signed [ProdW-1:0] shifted;
   logic signed [SumW-1:0]  inc;
   logic signed [SumW-1:0]  last_ext;
   logic signed [SumW-1:0]  sum;
   logic [SumW-PoseW:0]     top_bits;

   assign diff    = {last[PoseW-1], last} - {prev[PoseW-1], prev};
   assign prod_in = ProdW'(diff) * ProdW'($signed({1'b0, ext}));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign shifted  = prod_ff >>> FracW;
   assign inc      = shifted[SumW-1:0];
   assign last_ext = {{(SumW - PoseW){last[PoseW-1]}}, last};
   assign sum      = inc + last_ext;
   assign top_bits = sum[SumW-1:PoseW-1];

   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         result = sum[PoseW-1:0];
      end else if (sum[SumW-1]) begin
         result = {1'b1, {(PoseW - 1){1'b0}}};
      end else begin
         result = {1'b0, {(PoseW - 1){1'b1}}};
      end
   end

endmodule

>>> verif/tb_pose_extrapolator_core.sv
// testbench for pose_extrapolator_core: random frame and query words checked against a pose predictor
`timescale 1ns / 1ps

module tb_pose_extrapolator_core import pext_pkg::*;;

   localparam int WatchdogLimit = 3000;
   localparam int SettleCycles  = 120;
   localparam int PhaseWords    = 205;
   localparam int ReqBits       = $bits(req_word_type);

   localparam logic [CsrIdxW-1:0] CsrSpareLo = 2'd2;
   localparam logic [CsrIdxW-1:0] CsrSpareHi = 2'd3;

   localparam pose_type PoseLow  = 32'h8000_0000;
   localparam pose_type PoseHigh = 32'h7fff_ffff;
   localparam longint   SatHigh  = 64'sd2147483647;
   localparam longint   SatLow   = -64'sd2147483648;

   class pose_scoreboard;
      longint           knee;
      longint           asym;
      pose_type         last_pose[Axes];
      pose_type         old_pose[Axes];
      logic [TimeW-1:0] last_time;
      logic [TimeW-1:0] prev_time;
      logic [31:0]      frame_count;
      rsp_word_type     predicted_poses[$];
      int               mismatches;

      function new();
         knee = longint'(KneeReset);
         asym = longint'(AsymReset);
         for (int i = 0; i < Axes; i++) begin
            last_pose[i] = '0;
            old_pose[i]  = '0;
         end
         last_time   = '0;
         prev_time   = '0;
         frame_count = '0;
         mismatches  = 0;
      endfunction

      function void set_reg(logic [CsrIdxW-1:0] index, logic [RegW-1:0] data);
         if (index == CsrKnee) begin
            knee = longint'(data);
         end else if (index == CsrAsym) begin
            asym = longint'(data);
         end
      endfunction

      function int pending();
         return predicted_poses.size();
      endfunction

      // time ratio in q.16, bent onto the curve above the knee
      function longint calc_ratio(logic [TimeW-1:0] now);
         logic [TimeW-1:0]  num;
         logic [TimeW-1:0]  den;
         longint unsigned   r;
         longint unsigned   q;
         longint unsigned   mag;
         longint            gap;
         num = now - last_time;
         den = last_time - prev_time;
         if (den == 0) begin
            return 0;
         end
         r = ({32'h0, num} << FracW) / {32'h0, den};
         if (r <= knee) begin
            return longint'(r);
         end
         gap = asym - knee;
         mag = (gap < 0) ? -gap : gap;
         q = (knee * mag) / r;
         if (gap < 0) begin
            return asym + longint'(q);
         end
         return asym - longint'(q);
      endfunction

      function pose_type predict_axis(pose_type prev, pose_type last, longint ext);
         longint d;
         longint p;
         longint s;
         d = longint'(last) - longint'(prev);
         p = d * ext;
         s = longint'(last) + (p >>> FracW);
         if (s > SatHigh) begin
            s = SatHigh;
         end
         if (s < SatLow) begin
            s = SatLow;
         end
         return s[31:0];
      endfunction

      function void note_word(req_word_type w);
         rsp_word_type e;
         longint       ext;
         if (w.func == FuncStore) begin
            old_pose     = last_pose;
            last_pose[0] = w.in_yaw;
            last_pose[1] = w.in_pitch;
            last_pose[2] = w.in_roll;
            last_pose[3] = w.in_x;
            last_pose[4] = w.in_y;
            last_pose[5] = w.in_z;
            prev_time    = last_time;
            last_time    = w.time_stamp;
            frame_count  = w.in_count;
         end else begin
            e = '0;
            if (w.tracker_ok) begin
               ext = calc_ratio(w.time_stamp);
               e.out_yaw   = predict_axis(old_pose[0], last_pose[0], ext);
               e.out_pitch = predict_axis(old_pose[1], last_pose[1], ext);
               e.out_roll  = predict_axis(old_pose[2], last_pose[2], ext);
               e.out_x     = predict_axis(old_pose[3], last_pose[3], ext);
               e.out_y     = predict_axis(old_pose[4], last_pose[4], ext);
               e.out_z     = predict_axis(old_pose[5], last_pose[5], ext);
               e.out_count = frame_count;
               e.new_data  = (frame_count != w.known_count);
            end
            predicted_poses.push_back(e);
         end
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch on %s: expected %h, got %h", name, want, got);
            end
         end
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         if (predicted_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected word: out_count %h new_data %b", got.out_count,
                        got.new_data);
            end
         end else begin
            want = predicted_poses.pop_front();
            check_field("out_yaw", want.out_yaw, got.out_yaw);
            check_field("out_pitch", want.out_pitch, got.out_pitch);
            check_field("out_roll", want.out_roll, got.out_roll);
            check_field("out_x", want.out_x, got.out_x);
            check_field("out_y", want.out_y, got.out_y);
            check_field("out_z", want.out_z, got.out_z);
            check_field("out_count", want.out_count, got.out_count);
            check_field("new_data", 32'(want.new_data), 32'(got.new_data));
         end
      endfunction
   endclass

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_word_type       req_word  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_word_type       rsp_word;
   logic               csr_we    = 1'b0;
   logic [CsrIdxW-1:0] csr_index = CsrKnee;
   logic [RegW-1:0]    csr_data  = '0;

   pose_scoreboard sb = new();
   logic [31:0]    frame_dt   = 32'd1000;
   int             burst_left = 0;

   pose_extrapolator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_word(rsp_word);
      end
   end

   initial begin : stall_gen
      int run_left;
      int pick;
      run_left = 0;
      forever begin
         @(negedge clock);
         if (run_left > 0) begin
            run_left--;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               rsp_stall <= 1'b0;
               run_left = $urandom_range(0, 15);
            end else if (pick < 55) begin
               rsp_stall <= 1'b0;
               run_left = $urandom_range(100, 300);
            end else if (pick < 95) begin
               rsp_stall <= 1'b1;
               run_left = $urandom_range(0, 3);
            end else begin
               rsp_stall <= 1'b1;
               run_left = $urandom_range(20, 60);
            end
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WatchdogLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Some tests failed");
      $finish;
   end

   function automatic int pick_gap();
      int pick;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      if (pick < 45) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_word_type random_word();
      logic [319:0] bits;
      for (int i = 0; i < 10; i++) begin
         bits[i*32 +: 32] = $urandom();
      end
      return bits[ReqBits-1:0];
   endfunction

   function automatic pose_type rand_pose();
      case ($urandom_range(0, 5))
         0: return PoseLow;
         1: return PoseHigh;
         2: return '0;
         default: return $urandom();
      endcase
   endfunction

   function automatic pose_type drift(pose_type base);
      case ($urandom_range(0, 9))
         0: return rand_pose();
         1, 2: return base + pose_type'(int'($urandom_range(0, 32'h00ff_ffff)) - 8388608);
         3: return base;
         default: return base + pose_type'(int'($urandom_range(0, 8191)) - 4096);
      endcase
   endfunction

   function automatic logic [31:0] pick_interval();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return $urandom();
         2: return $urandom_range(1, 16);
         default: return $urandom_range(17, 20000);
      endcase
   endfunction

   function automatic req_word_type make_frame();
      req_word_type w;
      w = random_word();
      w.func = FuncStore;
      if ($urandom_range(0, 19) == 0) begin
         frame_dt = pick_interval();
      end
      w.time_stamp = sb.last_time + frame_dt;
      if ($urandom_range(0, 3) == 0) begin
         w.time_stamp = w.time_stamp + $urandom_range(0, 7);
      end
      w.in_yaw   = drift(sb.last_pose[0]);
      w.in_pitch = drift(sb.last_pose[1]);
      w.in_roll  = drift(sb.last_pose[2]);
      w.in_x     = drift(sb.last_pose[3]);
      w.in_y     = drift(sb.last_pose[4]);
      w.in_z     = drift(sb.last_pose[5]);
      if ($urandom_range(0, 7) != 0) begin
         w.in_count = sb.frame_count + 1;
      end
      return w;
   endfunction

   function automatic req_word_type make_query();
      req_word_type    w;
      longint unsigned span;
      longint unsigned num;
      int              pick;
      w = random_word();
      w.func = FuncQuery;
      span = {32'h0, sb.last_time - sb.prev_time};
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
         num = (span * $urandom_range(0, 64)) >> 4;
      end else if (pick < 18) begin
         num = (span * $urandom_range(0, 1024)) >> 4;
      end else begin
         num = $urandom();
      end
      w.time_stamp = sb.last_time + num[31:0];
      w.tracker_ok = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 3))
         0: w.known_count = sb.frame_count - 1;
         1: ;
         default: w.known_count = sb.frame_count;
      endcase
      return w;
   endfunction

   function automatic req_word_type next_word();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) return make_frame();
      if (pick < 90) return make_query();
      return random_word();
   endfunction

   // enters and leaves just after a falling edge with no input assigned yet
   task automatic send_word(input req_word_type w);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_word(w);
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [31:0] ts, input pose_type p, input logic [31:0] cnt);
      req_word_type w;
      w = random_word();
      w.func       = FuncStore;
      w.time_stamp = ts;
      w.in_yaw     = p;
      w.in_pitch   = ~p;
      w.in_roll    = p;
      w.in_x       = ~p;
      w.in_y       = p;
      w.in_z       = ~p;
      w.in_count   = cnt;
      send_word(w);
   endtask

   task automatic send_query(input logic [31:0] ts, input logic [31:0] known, input logic ok);
      req_word_type w;
      w = random_word();
      w.func        = FuncQuery;
      w.time_stamp  = ts;
      w.known_count = known;
      w.tracker_ok  = ok;
      send_word(w);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic set_regs(input logic [RegW-1:0] knee, input logic [RegW-1:0] asym);
      csr_we    <= 1'b1;
      csr_index <= CsrKnee;
      csr_data  <= knee;
      sb.set_reg(CsrKnee, knee);
      @(negedge clock);
      csr_index <= CsrAsym;
      csr_data  <= asym;
      sb.set_reg(CsrAsym, asym);
      @(negedge clock);
      // unused indexes must leave both registers alone
      csr_index <= ($urandom_range(0, 1) != 0) ? CsrSpareHi : CsrSpareLo;
      csr_data  <= RegW'($urandom());
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_phase(input logic [RegW-1:0] knee, input logic [RegW-1:0] asym);
      settle();
      set_regs(knee, asym);
      repeat (PhaseWords) send_word(next_word());
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // nothing stored yet, then tracker down
      send_query(32'h0, 32'h0, 1'b1);
      send_query(32'h0, 32'h5, 1'b1);
      send_query($urandom(), $urandom(), 1'b0);
      // full-scale swing between two frames drives every axis into saturation
      send_frame(32'h0, PoseLow, 32'hffff_ffff);
      send_frame(32'd100, PoseHigh, 32'h1);
      send_query(32'd150, 32'h1, 1'b1);
      send_query(32'd100, 32'h1, 1'b1);
      send_query(32'd1100, 32'h0, 1'b1);
      send_query(32'd99, 32'h1, 1'b1);
      // zero frame interval
      send_frame(32'd100, '0, 32'h1);
      send_query(32'd500, 32'h1, 1'b1);
      // interval across the timestamp wrap, ratio at and just past the knee
      send_frame(32'hffff_fff0, 32'h0001_0000, 32'h2);
      send_frame(32'h10, 32'h0003_0000, 32'h3);
      send_query(32'h20, 32'h3, 1'b1);
      send_query(32'h70, 32'h3, 1'b1);
      send_query(32'h71, 32'h2, 1'b1);
      send_query(32'hffff_ffff, 32'h3, 1'b1);
      send_query(32'h30, 32'h3, 1'b0);

      run_phase(20'd0, 20'd327680);
      run_phase(20'hfffff, 20'hfffff);
      run_phase(20'hfffff, 20'd0);
      run_phase(20'd196608, 20'd65536);
      run_phase(20'd0, 20'd0);
      run_phase(20'd65536, 20'hfffff);
      run_phase(RegW'($urandom_range(0, 20'hfffff)), RegW'($urandom_range(0, 20'hfffff)));
      settle();

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
